// ----- sv/tiba_pkg.sv -----
// tiba_pkg: shared widths, register map and reset values for the temporal
// iir band-pass amplifier. no dependencies.
package tiba_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 9;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 10;
    localparam int TRK_W    = 24;
    localparam int BAND_W   = 27;

    // apb register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_COEF_LOW  = 2'd0,
        REG_COEF_HIGH = 2'd1,
        REG_GAIN      = 2'd2
    } tiba_reg_t;

    localparam logic [COEF_W-1:0] COEF_LOW_RST  = 16'd7646;
    localparam logic [COEF_W-1:0] COEF_HIGH_RST = 16'd8738;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 10'd100;

    localparam logic signed [BAND_W-1:0] BAND_MAX = 27'sh3ff_ffff;
    localparam logic signed [BAND_W-1:0] BAND_MIN = -27'sh400_0000;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic in_range;
        logic prime;
    } tiba_ctl_t;

endpackage

// ----- sv/tiba_stream_if.sv -----
// tiba_in_if / tiba_out_if: valid/ready channels for samples and results.
// depends on tiba_pkg.
interface tiba_in_if import tiba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic [POS_W-1:0]    position;
    logic                frame_end;
    logic                restart;

    modport source (output valid, sample_value, position, frame_end, restart, input ready);
    modport sink   (input valid, sample_value, position, frame_end, restart, output ready);
endinterface

interface tiba_out_if import tiba_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [BAND_W-1:0] amplified_band;
    logic                     priming;

    modport source (output valid, amplified_band, priming, input ready);
    modport sink   (input valid, amplified_band, priming, output ready);
endinterface

// ----- sv/temporal_iir_bandpass_amplifier_core.sv -----
// temporal_iir_bandpass_amplifier_core: per-position dual low-pass trackers in
// on-chip memory, band-pass difference times gain. depends on tiba_pkg and the
// stream interfaces in tiba_stream_if.sv.
//
// usage: samples arrive on sample_in (valid/ready), each tagged with its
// position in the frame; one result per sample leaves on band_out in the same
// order. coefficients and gain sit in an apb register file (0x0 coef_low,
// 0x4 coef_high, 0x8 gain); the user must change them only while the block is
// idle; the block itself does not enforce this. throughput: one transaction
// per clock unless band_out stalls, for any mix of positions. the tracker
// memories are read at the accepting edge and written back as the transaction
// leaves stage 2; a two-entry write history forwards values not yet seen by
// a read, so repeated positions never stall. stages: read, premultiply,
// tracker update, gain multiply, round/saturate into the output register.
// a stall on band_out first fills the pipeline bubbles; sample_in.ready only
// drops once every stage holds a transaction and the output is not taken.
// reset clears the pipeline, loads the register defaults and puts the block in
// priming mode: the first frame only loads the trackers and returns zeros
// flagged as priming. the tracker memories are not cleared.
module temporal_iir_bandpass_amplifier_core
    import tiba_pkg::*;
#(
    parameter int unsigned FRAME_POSITIONS = 300
)(
    input  logic               clk,
    input  logic               rst_n,
    tiba_in_if.sink            sample_in,
    tiba_out_if.source         band_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned AW     = (FRAME_POSITIONS > 1) ? $clog2(FRAME_POSITIONS) : 1;
    localparam int          PCMP_W = 13;
    localparam logic [PCMP_W-1:0] NPOS = PCMP_W'(FRAME_POSITIONS);
    localparam int          ACC_W  = 41;
    localparam int          XC_W   = 40;
    localparam int          PROD_W = TRK_W + 1 + GAIN_W + 1;
    localparam int          Q_W    = PROD_W + 1 - 8;

    typedef logic [AW-1:0] addr_t;

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] coef_low_reg;
    logic [COEF_W-1:0] coef_high_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              cfg_wr;
    tiba_reg_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = tiba_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_low_reg  <= COEF_LOW_RST;
            coef_high_reg <= COEF_HIGH_RST;
            gain_reg      <= GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_COEF_LOW:  coef_low_reg  <= pwdata[COEF_W-1:0];
                REG_COEF_HIGH: coef_high_reg <= pwdata[COEF_W-1:0];
                REG_GAIN:      gain_reg      <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_COEF_LOW:  prdata = PDATA_W'(coef_low_reg);
            REG_COEF_HIGH: prdata = PDATA_W'(coef_high_reg);
            REG_GAIN:      prdata = PDATA_W'(gain_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage is free when empty or moving on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic free1, free2, free3, free4, free_out;
    logic accept;

    assign free_out = !out_valid_reg | band_out.ready;
    assign free4    = !s4_valid_reg | free_out;
    assign free3    = !s3_valid_reg | free4;
    assign free2    = !s2_valid_reg | free3;
    assign free1    = !s1_valid_reg | free2;

    assign sample_in.ready = free1;
    assign accept          = sample_in.valid & free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
                s1_valid_reg <= sample_in.valid;
            if (free2)
                s2_valid_reg <= s1_valid_reg;
            if (free3)
                s3_valid_reg <= s2_valid_reg;
            if (free4)
                s4_valid_reg <= s3_valid_reg;
            if (free_out)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // input: priming decision, range check, memory read
    // ------------------------------------------------------------------
    logic      priming_mode_reg;
    logic      priming_mode_next;
    tiba_ctl_t in_ctl;
    addr_t     rd_addr;

    assign in_ctl.prime    = priming_mode_reg | sample_in.restart;
    assign in_ctl.in_range = {{(PCMP_W-POS_W){1'b0}}, sample_in.position} < NPOS;
    assign rd_addr         = addr_t'(sample_in.position);
    assign priming_mode_next = sample_in.frame_end ? 1'b0 : in_ctl.prime;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            priming_mode_reg <= 1'b1;
        else if (accept)
            priming_mode_reg <= priming_mode_next;
    end

    logic [TRK_W-1:0] fast_mem [FRAME_POSITIONS];
    logic [TRK_W-1:0] slow_mem [FRAME_POSITIONS];
    logic [TRK_W-1:0] rd_fast_reg;
    logic [TRK_W-1:0] rd_slow_reg;
    logic             wr_en;
    addr_t            s2_addr_reg;
    logic [TRK_W-1:0] wr_fast;
    logic [TRK_W-1:0] wr_slow;

    // read returns the old contents on a same-edge write; the history covers it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fast_mem[s2_addr_reg] <= wr_fast;
            slow_mem[s2_addr_reg] <= wr_slow;
        end
        if (accept && in_ctl.in_range)
        begin
            rd_fast_reg <= fast_mem[rd_addr];
            rd_slow_reg <= slow_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: sample times coefficient, independent of the tracker
    // ------------------------------------------------------------------
    tiba_ctl_t           s1_ctl_reg;
    addr_t               s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [31:0]         xch_prod;
    logic [31:0]         xcl_prod;
    logic [XC_W-1:0]     xcf_next;
    logic [XC_W-1:0]     xcs_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg    <= in_ctl;
            s1_addr_reg   <= rd_addr;
            s1_sample_reg <= sample_in.sample_value;
        end
    end

    assign xch_prod = s1_sample_reg * coef_high_reg;
    assign xcl_prod = s1_sample_reg * coef_low_reg;
    // x16 * c plus the rounding half
    assign xcf_next = {xch_prod, 8'd0} + XC_W'(32768);
    assign xcs_next = {xcl_prod, 8'd0} + XC_W'(32768);

    // ------------------------------------------------------------------
    // stage 2: tracker update and write-back
    // ------------------------------------------------------------------
    tiba_ctl_t        s2_ctl_reg;
    logic [TRK_W-1:0] s2_x16_reg;
    logic [XC_W-1:0]  s2_xcf_reg;
    logic [XC_W-1:0]  s2_xcs_reg;
    logic [TRK_W-1:0] s2_tf_reg;
    logic [TRK_W-1:0] s2_ts_reg;

    always_ff @(posedge clk)
    begin
        if (free2 && s1_valid_reg)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_x16_reg  <= {s1_sample_reg, 8'd0};
            s2_xcf_reg  <= xcf_next;
            s2_xcs_reg  <= xcs_next;
            s2_tf_reg   <= rd_fast_reg;
            s2_ts_reg   <= rd_slow_reg;
        end
    end

    // last two writes, newest first
    logic             wh1_valid_reg, wh2_valid_reg;
    addr_t            wh1_addr_reg, wh2_addr_reg;
    logic [TRK_W-1:0] wh1_fast_reg, wh2_fast_reg;
    logic [TRK_W-1:0] wh1_slow_reg, wh2_slow_reg;
    logic             hit1, hit2;
    logic [TRK_W-1:0] tf, ts;
    logic [COEF_W:0]  cmf, cms;
    logic [ACC_W-1:0] mulf, muls;
    logic [ACC_W-1:0] accf, accs;
    logic [TRK_W-1:0] f_upd, s_upd;

    assign hit1 = wh1_valid_reg && (wh1_addr_reg == s2_addr_reg);
    assign hit2 = wh2_valid_reg && (wh2_addr_reg == s2_addr_reg);

    always_comb
    begin
        if (hit1)
        begin
            tf = wh1_fast_reg;
            ts = wh1_slow_reg;
        end
        else if (hit2)
        begin
            tf = wh2_fast_reg;
            ts = wh2_slow_reg;
        end
        else
        begin
            tf = s2_tf_reg;
            ts = s2_ts_reg;
        end
    end

    // t' = (t * (65536 - c) + x16 * c + 32768) >> 16
    assign cmf  = (COEF_W+1)'(65536) - {1'b0, coef_high_reg};
    assign cms  = (COEF_W+1)'(65536) - {1'b0, coef_low_reg};
    assign mulf = tf * cmf;
    assign muls = ts * cms;
    assign accf = mulf + {1'b0, s2_xcf_reg};
    assign accs = muls + {1'b0, s2_xcs_reg};
    assign f_upd = accf[TRK_W+15:16];
    assign s_upd = accs[TRK_W+15:16];

    assign wr_fast = s2_ctl_reg.prime ? s2_x16_reg : f_upd;
    assign wr_slow = s2_ctl_reg.prime ? s2_x16_reg : s_upd;
    assign wr_en   = s2_valid_reg & free3 & s2_ctl_reg.in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wh1_valid_reg <= 1'b0;
            wh2_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            wh1_valid_reg <= 1'b1;
            wh2_valid_reg <= wh1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wh1_addr_reg <= s2_addr_reg;
            wh1_fast_reg <= wr_fast;
            wh1_slow_reg <= wr_slow;
            wh2_addr_reg <= wh1_addr_reg;
            wh2_fast_reg <= wh1_fast_reg;
            wh2_slow_reg <= wh1_slow_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: band-pass difference times gain
    // ------------------------------------------------------------------
    tiba_ctl_t                s3_ctl_reg;
    logic [TRK_W-1:0]         s3_fast_reg;
    logic [TRK_W-1:0]         s3_slow_reg;
    logic signed [TRK_W:0]    diff3;
    logic signed [PROD_W-1:0] prod3;

    always_ff @(posedge clk)
    begin
        if (free3 && s2_valid_reg)
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_fast_reg <= f_upd;
            s3_slow_reg <= s_upd;
        end
    end

    assign diff3 = $signed({1'b0, s3_fast_reg}) - $signed({1'b0, s3_slow_reg});
    assign prod3 = diff3 * $signed({1'b0, gain_reg});

    // ------------------------------------------------------------------
    // stage 4: round half up to q.8, saturate, output register
    // ------------------------------------------------------------------
    tiba_ctl_t                s4_ctl_reg;
    logic signed [PROD_W-1:0] s4_prod_reg;
    logic signed [PROD_W:0]   rnd4;
    logic signed [Q_W-1:0]    q4;
    logic signed [BAND_W-1:0] band_next;

    always_ff @(posedge clk)
    begin
        if (free4 && s3_valid_reg)
        begin
            s4_ctl_reg  <= s3_ctl_reg;
            s4_prod_reg <= prod3;
        end
    end

    assign rnd4 = {s4_prod_reg[PROD_W-1], s4_prod_reg} + (PROD_W+1)'(128);
    assign q4   = rnd4[PROD_W:8];

    always_comb
    begin
        if (s4_ctl_reg.prime || !s4_ctl_reg.in_range)
            band_next = '0;
        else if ((q4[Q_W-1:BAND_W-1] == '0) || (q4[Q_W-1:BAND_W-1] == '1))
            band_next = q4[BAND_W-1:0];
        else if (q4[Q_W-1])
            band_next = BAND_MIN;
        else
            band_next = BAND_MAX;
    end

    logic signed [BAND_W-1:0] out_band_reg;
    logic                     out_priming_reg;

    always_ff @(posedge clk)
    begin
        if (free_out && s4_valid_reg)
        begin
            out_band_reg    <= band_next;
            out_priming_reg <= s4_ctl_reg.prime;
        end
    end

    assign band_out.valid          = out_valid_reg;
    assign band_out.amplified_band = out_band_reg;
    assign band_out.priming        = out_priming_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the frame end always leaves priming mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready && sample_in.frame_end) |=> !priming_mode_reg)
        else $error("priming mode survived a frame end");

    // a priming result never carries a filtered value
    assert property (@(posedge clk) disable iff (!rst_n)
        (band_out.valid && band_out.priming) |-> (band_out.amplified_band == '0))
        else $error("priming transaction with nonzero band value");

    // input back-pressure only comes from a stalled, full output
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_in.ready |-> (band_out.valid && !band_out.ready))
        else $error("input stalled without output back-pressure");

    // a write-back only happens for an in-range transaction leaving stage 2
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s2_valid_reg && s2_ctl_reg.in_range && (s3_valid_reg ? free4 : 1'b1)))
        else $error("tracker write-back without a moving transaction");

endmodule

// ----- verif/tb_temporal_iir_bandpass_amplifier_core.sv -----
// self-checking testbench for temporal_iir_bandpass_amplifier_core: a directed
// table, then framed random traffic under changing idle patterns and apb settings.
// depends on tiba_pkg, tiba_stream_if.sv and the core itself.
`timescale 1ns / 100ps

module tb_temporal_iir_bandpass_amplifier_core;
    import tiba_pkg::*;

    localparam int FRAME_POS   = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 240;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]    pos;
        logic                fend;
        logic                rst;
    } sample_t;

    typedef struct packed {
        logic signed [BAND_W-1:0] band;
        logic                     prime;
    } band_rec_t;

    typedef struct packed {
        logic      pinned;
        band_rec_t rec;
    } pin_rec_t;

    typedef struct packed {
        sample_t   smp;
        pin_rec_t  want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    tiba_in_if  sample_in_if ();
    tiba_out_if band_out_if ();

    temporal_iir_bandpass_amplifier_core #(
        .FRAME_POSITIONS (FRAME_POS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in_if),
        .band_out  (band_out_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // predictor state: register shadow, trackers, priming
    logic [COEF_W-1:0] cfg_coef_low;
    logic [COEF_W-1:0] cfg_coef_high;
    logic [GAIN_W-1:0] cfg_gain;
    logic [TRK_W-1:0]  fast_trk [FRAME_POS];
    logic [TRK_W-1:0]  slow_trk [FRAME_POS];
    bit                trk_loaded [FRAME_POS];
    logic              prime_mode;

    band_rec_t band_expect_q [$];
    pin_rec_t  pinned_band_q [$];
    int        mismatch_count;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;

    dir_row_t dir_rows [17];

    function automatic logic [TRK_W-1:0] track_lowpass(logic [TRK_W-1:0] t,
                                                       logic [TRK_W-1:0] x16,
                                                       logic [COEF_W-1:0] c);
        logic [41:0] acc;
        acc = 42'(t) * (42'd65536 - 42'(c)) + 42'(x16) * 42'(c) + 42'd32768;
        return acc[39:16];
    endfunction

    function automatic void predict_band(input sample_t s, output band_rec_t r);
        logic prime;
        logic [TRK_W-1:0] x16;
        logic [TRK_W-1:0] f;
        logic [TRK_W-1:0] sl;
        logic signed [TRK_W:0] d;
        longint p;
        longint q;
        prime   = prime_mode | s.rst;
        r.band  = '0;
        r.prime = prime;
        if (s.pos < FRAME_POS)
        begin
            x16 = {s.value, 8'h00};
            if (prime)
            begin
                fast_trk[s.pos] = x16;
                slow_trk[s.pos] = x16;
            end
            else
            begin
                f  = track_lowpass(fast_trk[s.pos], x16, cfg_coef_high);
                sl = track_lowpass(slow_trk[s.pos], x16, cfg_coef_low);
                fast_trk[s.pos] = f;
                slow_trk[s.pos] = sl;
                d = $signed({1'b0, f}) - $signed({1'b0, sl});
                p = longint'(d) * longint'({1'b0, cfg_gain});
                // arithmetic shift gives floor, so this rounds half up
                q = (p + 64'sd128) >>> 8;
                if (q > longint'(BAND_MAX))
                    q = longint'(BAND_MAX);
                if (q < longint'(BAND_MIN))
                    q = longint'(BAND_MIN);
                r.band = q[BAND_W-1:0];
            end
            trk_loaded[s.pos] = 1'b1;
        end
        prime_mode = s.fend ? 1'b0 : prime;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // transaction monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        band_rec_t r;
        pin_rec_t  pin;
        sample_t   s;
        if (rst_n)
        begin
            if (sample_in_if.valid && sample_in_if.ready)
            begin
                s = '{sample_in_if.sample_value, sample_in_if.position,
                      sample_in_if.frame_end, sample_in_if.restart};
                predict_band(s, r);
                pin = '0;
                if (pinned_band_q.size() != 0)
                    pin = pinned_band_q.pop_front();
                band_expect_q = {band_expect_q, (pin.pinned ? pin.rec : r)};
            end
            if (band_out_if.valid && band_out_if.ready)
            begin
                if (band_expect_q.size() == 0)
                    report_mismatch("result with nothing pending", band_out_if.amplified_band, 0);
                else
                begin
                    r = band_expect_q.pop_front();
                    if (band_out_if.amplified_band !== r.band)
                        report_mismatch("amplified_band", band_out_if.amplified_band, r.band);
                    if (band_out_if.priming !== r.prime)
                        report_mismatch("priming", band_out_if.priming, r.prime);
                end
            end
        end
    end

    // result receiver: random stalls plus an occasional long hold-off
    initial
    begin
        band_out_if.ready = 1'b0;
        holds_served = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                band_out_if.ready = 1'b0;
            end
            else
                band_out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_sample(sample_t s, pin_rec_t pin);
        @(negedge clk);
        // never let a filtered sample read a tracker entry that was never loaded
        if (s.pos < FRAME_POS && !prime_mode && !s.rst && !trk_loaded[s.pos])
            s.rst = 1'b1;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_in_if.valid = 1'b0;
            @(negedge clk);
        end
        sample_in_if.sample_value = s.value;
        sample_in_if.position     = s.pos;
        sample_in_if.frame_end    = s.fend;
        sample_in_if.restart      = s.rst;
        sample_in_if.valid        = 1'b1;
        pinned_band_q = {pinned_band_q, pin};
        do
            @(posedge clk);
        while (!sample_in_if.ready);
    endtask

    task automatic wait_drained(int settle);
        @(negedge clk);
        sample_in_if.valid = 1'b0;
        while (band_expect_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(tiba_reg_t idx, logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] got;
        case (idx)
            REG_COEF_LOW:  cfg_coef_low  = data[COEF_W-1:0];
            REG_COEF_HIGH: cfg_coef_high = data[COEF_W-1:0];
            REG_GAIN:      cfg_gain      = data[GAIN_W-1:0];
            default: ;
        endcase
        want = (idx == REG_GAIN) ? PDATA_W'(cfg_gain)
             : (idx == REG_COEF_LOW) ? PDATA_W'(cfg_coef_low) : PDATA_W'(cfg_coef_high);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // read back through the same port
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want)
            report_mismatch("register readback", got, want);
    endtask

    // framed traffic: mostly well-formed frames over positions 0..frame_len-1,
    // some shuffled, some noise frames with arbitrary fields
    task automatic run_frames(int n_items, int frame_len, bit pressure);
        int n;
        int len;
        bit noise;
        bit shuffle;
        sample_t s;
        n = 0;
        while (n < n_items)
        begin
            noise   = ($urandom_range(0, 9) == 0);
            shuffle = ($urandom_range(0, 3) == 0);
            len     = noise ? $urandom_range(1, 20) : frame_len;
            for (int k = 0; k < len && n < n_items; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       s.value = '0;
                    1:       s.value = '1;
                    default: s.value = SAMPLE_W'($urandom);
                endcase
                if (noise)
                begin
                    s.pos  = POS_W'($urandom);
                    s.fend = 1'($urandom_range(0, 1));
                    s.rst  = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    s.pos  = shuffle ? POS_W'($urandom_range(0, frame_len - 1)) : POS_W'(k);
                    if ($urandom_range(0, 19) == 0)
                        s.pos = POS_W'($urandom_range(FRAME_POS, 511));
                    s.fend = (k == len - 1);
                    s.rst  = ($urandom_range(0, 63) == 0);
                end
                if (pressure && n == 40)
                    hold_requests++;
                if (pressure && n == 200)
                    wait_drained(0);
                send_sample(s, '0);
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_in_if.valid = 1'b0;
        sample_in_if.sample_value = '0;
        sample_in_if.position = '0;
        sample_in_if.frame_end = 1'b0;
        sample_in_if.restart = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        mismatch_count = 0;
        cfg_coef_low = COEF_LOW_RST;
        cfg_coef_high = COEF_HIGH_RST;
        cfg_gain = GAIN_RST;
        prime_mode = 1'b1;
        foreach (trk_loaded[i])
            trk_loaded[i] = 1'b0;

        // value, position, frame_end, restart | pinned, band, priming
        dir_rows = '{
            '{'{16'h0000, 9'd0,   1'b0, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},  // first frame primes
            '{'{16'hffff, 9'd299, 1'b0, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},
            '{'{16'h1234, 9'd300, 1'b0, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},  // out of range
            '{'{16'h0000, 9'd511, 1'b1, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},
            '{'{16'hffff, 9'd0,   1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'h0000, 9'd299, 1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'h0005, 9'd511, 1'b0, 1'b0}, '{1'b1, '{27'sd0, 1'b0}}},
            '{'{16'hffff, 9'd0,   1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'h8000, 9'd1,   1'b0, 1'b1}, '{1'b1, '{27'sd0, 1'b1}}},  // restart
            '{'{16'h7fff, 9'd2,   1'b0, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},  // restart holds
            '{'{16'h0001, 9'd400, 1'b1, 1'b0}, '{1'b1, '{27'sd0, 1'b1}}},
            '{'{16'h0000, 9'd1,   1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'hffff, 9'd2,   1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'h00ff, 9'd299, 1'b0, 1'b1}, '{1'b1, '{27'sd0, 1'b1}}},
            '{'{16'hff00, 9'd0,   1'b1, 1'b1}, '{1'b1, '{27'sd0, 1'b1}}},  // restart on frame end
            '{'{16'h0000, 9'd299, 1'b0, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}},
            '{'{16'haaaa, 9'd0,   1'b1, 1'b0}, '{1'b0, '{27'sd0, 1'b0}}}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_sample(dir_rows[i].smp, dir_rows[i].want);
        run_frames(300, 12, 1'b0);

        // extreme coefficients and full gain, slow sender
        wait_drained(8);
        write_reg(REG_COEF_LOW, 32'd0);
        write_reg(REG_COEF_HIGH, 32'd65535);
        write_reg(REG_GAIN, 32'd1023);
        send_idle_pct = 62;
        recv_stall_pct = 0;
        run_frames(330, 40, 1'b0);

        // opposite extremes, zero gain, slow receiver
        wait_drained(8);
        write_reg(REG_COEF_LOW, 32'd65535);
        write_reg(REG_COEF_HIGH, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        run_frames(330, 3, 1'b0);

        // random settings with garbage in the unused upper bits
        wait_drained(8);
        write_reg(REG_COEF_LOW, $urandom);
        write_reg(REG_COEF_HIGH, $urandom);
        write_reg(REG_GAIN, $urandom);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        run_frames(330, 300, 1'b0);

        // band-pass style settings, back-pressure and a full drain mid-stream
        wait_drained(8);
        write_reg(REG_COEF_LOW, $urandom_range(0, 4000));
        write_reg(REG_COEF_HIGH, $urandom_range(4000, 30000));
        write_reg(REG_GAIN, 32'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_frames(330, 25, 1'b1);

        wait_drained(10);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
